[hw/rtl/bsk_pkg.sv]
// ----------------------------------------------------------------------------
// Best set keeper package
// Shared widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package bsk_pkg;

  localparam int SetDepthDef = 16;
  localparam int KeyWidthDef = 64;

  localparam int KeyBits     = 64;
  localparam int CostBits    = 32;
  localparam int GenBits     = 16;
  localparam int TrialBits   = 32;
  localparam int IdxBits     = 4;
  localparam int CountBits   = 5;
  localparam int CapBits     = 5;
  localparam int KlenBits    = 7;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 7;

  typedef enum logic [2:0] {
    ActDup     = 3'd0,
    ActAppend  = 3'd1,
    ActReplace = 3'd2,
    ActReject  = 3'd3,
    ActRead    = 3'd4
  } action_e;

  typedef enum logic {
    ReqOffer = 1'b0,
    ReqRead  = 1'b1
  } req_type_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSetCapacity = 1'b0,
    CfgKeyLength   = 1'b1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } bsk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic scan_done;
    logic out_free;
  } bsk_sts_t;

endpackage

[hw/rtl/bsk_if.sv]
// ----------------------------------------------------------------------------
// Best set keeper channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsk_req_if import bsk_pkg::*; ;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [KeyBits-1:0]          key_bits;
  logic signed [CostBits-1:0]  cost;
  logic [GenBits-1:0]          generation;
  logic [TrialBits-1:0]        trial_count;
  logic [IdxBits-1:0]          read_index;

  modport source (
    output valid, req_type, key_bits, cost, generation, trial_count, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_bits, cost, generation, trial_count, read_index,
    output ready
  );
endinterface

interface bsk_rsp_if import bsk_pkg::*; ;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  action;
  logic [IdxBits-1:0]          slot;
  logic [CountBits-1:0]        stored_count;
  logic                        read_valid;
  logic [KeyBits-1:0]          read_key;
  logic signed [CostBits-1:0]  read_cost;
  logic [GenBits-1:0]          read_generation;
  logic [TrialBits-1:0]        read_trials;

  modport source (
    output valid, action, slot, stored_count, read_valid, read_key, read_cost,
           read_generation, read_trials,
    input  ready
  );
  modport sink (
    input  valid, action, slot, stored_count, read_valid, read_key, read_cost,
           read_generation, read_trials,
    output ready
  );
endinterface

[hw/rtl/best_set_keeper.sv]
// ----------------------------------------------------------------------------
// Best set keeper
// Keeps the lowest-cost candidates offered so far, rejecting duplicate keys.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time. An offer walks the stored
// entries through the single read port of the entry memory, one entry per
// cycle, and stops early on a key match. The result beat is loaded into
// the output register once the scan ends and that register is free; an
// offer to an empty set skips the scan, and a read request passes through
// a read wait state instead. The controller returns to idle on the cycle
// the result is loaded, so the next request beat can be accepted in the
// cycle that follows. The result sits in an output register, so a new
// request beat is accepted while the previous result beat still waits for
// the sink. Entries are never cleared: an entry slot at or above the stored
// count reads back as invalid with zero fields. Configuration writes (set
// capacity, key length) take effect at once and are expected only while
// the block is idle.
module best_set_keeper import bsk_pkg::*; #(
  parameter int SET_DEPTH = SetDepthDef,
  parameter int KEY_WIDTH = KeyWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  bsk_req_if.sink                req_i,
  bsk_rsp_if.source              rsp_o
);

  bsk_cmd_t cmd;
  bsk_sts_t sts;
  logic     in_ready;

  // The controller only sees the request valid and its type; the
  // datapath latches the payload when the controller issues a load.
  bsk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_type_i  (req_type_e'(req_i.req_type)),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  bsk_datapath #(
    .SET_DEPTH (SET_DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_e'(req_i.req_type)),
    .key_bits_i    (req_i.key_bits),
    .cost_i        (req_i.cost),
    .generation_i  (req_i.generation),
    .trial_count_i (req_i.trial_count),
    .read_index_i  (req_i.read_index),
    .rsp_o         (rsp_o)
  );

endmodule

[hw/rtl/bsk_ctrl.sv]
// ----------------------------------------------------------------------------
// Best set keeper controller
// Sequences load, entry scan, read wait and commit of one request.
// ----------------------------------------------------------------------------
module bsk_ctrl import bsk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  req_type_e in_type_i,
  output logic      in_ready_o,
  input  bsk_sts_t  sts_i,
  output bsk_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StRdWait = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_type_i == ReqRead) begin
            state_d = StRdWait;
          end else if (sts_i.cnt_zero) begin
            state_d = StFinish;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = !sts_i.scan_done;
        if (sts_i.scan_done) begin
          state_d = StFinish;
        end
      end
      StRdWait: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/bsk_datapath.sv]
// ----------------------------------------------------------------------------
// Best set keeper datapath
// Entry memory, configuration, scan compare and worst tracking, result register.
// ----------------------------------------------------------------------------
module bsk_datapath import bsk_pkg::*; #(
  parameter int SET_DEPTH = SetDepthDef,
  parameter int KEY_WIDTH = KeyWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i,
  input  bsk_cmd_t                    cmd_i,
  output bsk_sts_t                    sts_o,
  input  req_type_e                   req_type_i,
  input  logic [KeyBits-1:0]          key_bits_i,
  input  logic signed [CostBits-1:0]  cost_i,
  input  logic [GenBits-1:0]          generation_i,
  input  logic [TrialBits-1:0]        trial_count_i,
  input  logic [IdxBits-1:0]          read_index_i,
  bsk_rsp_if.source                   rsp_o
);

  localparam int IDXW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNTW = $clog2(SET_DEPTH + 1);
  localparam int CMPW = (CNTW > CapBits) ? CNTW : CapBits;
  localparam int EW   = KEY_WIDTH + CostBits + GenBits + TrialBits;

  // Configuration registers.
  logic [CapBits-1:0]  cap_q;
  logic [KlenBits-1:0] klen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapBits'(16);
      klen_q <= KlenBits'(64);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgSetCapacity: cap_q  <= cfg_data_i[CapBits-1:0];
        CfgKeyLength:   klen_q <= cfg_data_i[KlenBits-1:0];
        default: ;
      endcase
    end
  end

  // Bits at or above the key length are cleared; this also clamps lengths
  // beyond the key width.
  logic [KEY_WIDTH-1:0] key_mask;
  always_comb begin
    for (int b = 0; b < KEY_WIDTH; b++) begin
      key_mask[b] = (KlenBits'(b) < klen_q);
    end
  end

  // Latched request.
  req_type_e                  req_type_q;
  logic [KEY_WIDTH-1:0]       key_q;
  logic signed [CostBits-1:0] cost_q;
  logic [GenBits-1:0]         gen_q;
  logic [TrialBits-1:0]       trials_q;
  logic [IdxBits-1:0]         ridx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      key_q      <= key_bits_i[KEY_WIDTH-1:0] & key_mask;
      cost_q     <= cost_i;
      gen_q      <= generation_i;
      trials_q   <= trial_count_i;
      ridx_q     <= read_index_i;
    end
  end

  // Entry memory with a registered read port.
  logic [EW-1:0]   mem [SET_DEPTH];
  logic [EW-1:0]   rd_data_q;
  logic [IDXW-1:0] issue_q;
  logic [IDXW-1:0] rd_addr;
  logic            wr_en;
  logic [IDXW-1:0] wr_idx;

  assign rd_addr = (req_type_q == ReqRead) ? IDXW'(ridx_q) : issue_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem[wr_idx] <= {key_q, cost_q, gen_q, trials_q};
    end
    rd_data_q <= mem[rd_addr];
  end

  logic [KEY_WIDTH-1:0]       rd_key;
  logic signed [CostBits-1:0] rd_cost;
  logic [GenBits-1:0]         rd_gen;
  logic [TrialBits-1:0]       rd_trials;

  assign rd_key    = rd_data_q[EW-1 -: KEY_WIDTH];
  assign rd_cost   = signed'(rd_data_q[TrialBits+GenBits +: CostBits]);
  assign rd_gen    = rd_data_q[TrialBits +: GenBits];
  assign rd_trials = rd_data_q[TrialBits-1:0];

  // Scan: compares work on the read data of the address issued in the cycle before.
  logic [CNTW-1:0]            cnt_q;
  logic                       chk_vld_q;
  logic [IDXW-1:0]            chk_idx_q;
  logic                       dup_q;
  logic [IDXW-1:0]            dup_idx_q;
  logic                       worst_vld_q;
  logic signed [CostBits-1:0] worst_cost_q;
  logic [IDXW-1:0]            worst_idx_q;
  logic                       hit;
  logic                       chk_last;

  assign hit      = (((rd_key ^ key_q) & key_mask) == '0);
  assign chk_last = ((CNTW'(chk_idx_q) + CNTW'(1)) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= '0;
      chk_vld_q   <= 1'b0;
      dup_q       <= 1'b0;
      worst_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.scan_step;
      if (cmd_i.load) begin
        issue_q     <= '0;
        dup_q       <= 1'b0;
        worst_vld_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          issue_q <= issue_q + IDXW'(1);
        end
        if (chk_vld_q) begin
          worst_vld_q <= 1'b1;
          if (hit) begin
            dup_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= issue_q;
    if (chk_vld_q) begin
      if (hit) begin
        dup_idx_q <= chk_idx_q;
      end
      // Strictly greater keeps the lowest slot among equal worst costs.
      if (!worst_vld_q || (rd_cost > worst_cost_q)) begin
        worst_cost_q <= rd_cost;
        worst_idx_q  <= chk_idx_q;
      end
    end
  end

  // Decision at commit.
  logic [CMPW-1:0]  cnt_ext;
  logic             below_cap;
  logic             rvalid;
  action_e          act_d;
  logic [IdxBits-1:0] slot_d;
  logic [CNTW-1:0]  cnt_d;

  assign cnt_ext   = CMPW'(cnt_q);
  assign below_cap = (cap_q == '0) ? (cnt_q == '0)
                   : ((cnt_ext < CMPW'(cap_q)) && (cnt_ext < CMPW'(SET_DEPTH)));
  assign rvalid    = (CMPW'(ridx_q) < cnt_ext);

  always_comb begin
    act_d  = ActReject;
    slot_d = '0;
    cnt_d  = cnt_q;
    wr_en  = 1'b0;
    wr_idx = worst_idx_q;
    if (req_type_q == ReqRead) begin
      act_d  = ActRead;
      slot_d = ridx_q;
    end else if (dup_q) begin
      act_d  = ActDup;
      slot_d = IdxBits'(dup_idx_q);
    end else if (below_cap) begin
      act_d  = ActAppend;
      slot_d = IdxBits'(cnt_q);
      cnt_d  = cnt_q + CNTW'(1);
      wr_en  = 1'b1;
      wr_idx = IDXW'(cnt_q);
    end else if (cost_q < worst_cost_q) begin
      act_d  = ActReplace;
      slot_d = IdxBits'(worst_idx_q);
      wr_en  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      cnt_q <= cnt_d;
    end
  end

  // Result register.
  logic                       out_vld_q;
  action_e                    out_act_q;
  logic [IdxBits-1:0]         out_slot_q;
  logic [CountBits-1:0]       out_cnt_q;
  logic                       out_rvalid_q;
  logic [KeyBits-1:0]         out_key_q;
  logic signed [CostBits-1:0] out_cost_q;
  logic [GenBits-1:0]         out_gen_q;
  logic [TrialBits-1:0]       out_trials_q;
  logic                       rd_hit;

  assign rd_hit = (req_type_q == ReqRead) && rvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_act_q    <= act_d;
      out_slot_q   <= slot_d;
      out_cnt_q    <= CountBits'(cnt_d);
      out_rvalid_q <= rd_hit;
      out_key_q    <= rd_hit ? KeyBits'(rd_key) : '0;
      out_cost_q   <= rd_hit ? rd_cost : '0;
      out_gen_q    <= rd_hit ? rd_gen : '0;
      out_trials_q <= rd_hit ? rd_trials : '0;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.action          = out_act_q;
  assign rsp_o.slot            = out_slot_q;
  assign rsp_o.stored_count    = out_cnt_q;
  assign rsp_o.read_valid      = out_rvalid_q;
  assign rsp_o.read_key        = out_key_q;
  assign rsp_o.read_cost       = out_cost_q;
  assign rsp_o.read_generation = out_gen_q;
  assign rsp_o.read_trials     = out_trials_q;

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.scan_done = chk_vld_q && (hit || chk_last);
  assign sts_o.out_free  = !out_vld_q || rsp_o.ready;

endmodule
